### src/dual_gradient_pixel_energy_assert.svh
// Assertion macros used by the RTL of the pixel energy block.
`ifndef DUAL_GRADIENT_PIXEL_ENERGY_ASSERT_SVH
`define DUAL_GRADIENT_PIXEL_ENERGY_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define DGPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define DGPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/dgpe_pkg.sv
`default_nettype none

package dgpe_pkg;

  // Field widths.
  localparam int unsigned CoordW  = 6;
  localparam int unsigned SizeW   = 7;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned EnergyW = 19;
  localparam int unsigned PairW   = 18;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Item kinds.
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One stored pixel.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // Square of the absolute difference of two channel values.
  function automatic logic [2*ChanW-1:0] chan_sq(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // Sum of the three squared channel differences of a pixel pair.
  function automatic logic [PairW-1:0] pair_energy(input pixel_t a, input pixel_t b);
    return PairW'(chan_sq(a.red, b.red)) + PairW'(chan_sq(a.green, b.green))
         + PairW'(chan_sq(a.blue, b.blue));
  endfunction

endpackage

`default_nettype wire

### src/dual_gradient_pixel_energy.sv
// Store word: written when accepted, and the next word may follow in the next cycle.
// Query word: the result is formed in S_READ and S_DRAIN and registered in S_PUSH; a
// query outside the frame goes straight to S_PUSH with a zero result. The input stalls
// until the result is registered: the four neighbour reads use the single memory port.
// Reset clears the control state and sets both frame sizes to 64 (or the maximum);
// the frame memory is not cleared and holds undefined pixels until written.
`default_nettype none

module dual_gradient_pixel_energy #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input word channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_kind_i,
  input  logic [dgpe_pkg::CoordW-1:0]  in_column_i,
  input  logic [dgpe_pkg::CoordW-1:0]  in_row_i,
  input  logic [dgpe_pkg::ChanW-1:0]   in_red_i,
  input  logic [dgpe_pkg::ChanW-1:0]   in_green_i,
  input  logic [dgpe_pkg::ChanW-1:0]   in_blue_i,
  // Result word channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dgpe_pkg::EnergyW-1:0] out_pixel_energy_o,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dgpe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dgpe_pkg::SizeW-1:0]   cfg_data_i
);
  import dgpe_pkg::*;

  `include "dual_gradient_pixel_energy_assert.svh"

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [10:0] MaxW  = 11'(MAX_WIDTH);
  localparam logic [10:0] MaxH  = 11'(MAX_HEIGHT);
  localparam logic [SizeW-1:0] WidthReset  = (MAX_WIDTH < 64) ? SizeW'(MAX_WIDTH) : 7'd64;
  localparam logic [SizeW-1:0] HeightReset = (MAX_HEIGHT < 64) ? SizeW'(MAX_HEIGHT) : 7'd64;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_PUSH
  } state_e;

  state_e               state_q;
  logic [1:0]           cnt_q;
  logic                 rd_pend_q;
  logic                 rd_odd_q;
  logic                 out_valid_q;
  logic [EnergyW-1:0]   out_energy_q;
  logic [SizeW-1:0]     width_q;
  logic [SizeW-1:0]     height_q;

  logic [SizeW-1:0]     col_q, row_q, left_q, right_q, up_q, down_q;
  pixel_t               hold_q;
  logic [EnergyW-1:0]   acc_q;

  pixel_t               mem_q [Depth];
  pixel_t               mem_rdata_q;
  logic [AddrW-1:0]     mem_addr;
  logic                 mem_we;
  pixel_t               wr_pixel;

  logic                 in_fire;
  logic                 query_fire;
  logic                 in_frame;
  logic                 in_store;
  logic [SizeW-1:0]     col_ext, row_ext;
  logic [SizeW-1:0]     rd_col, rd_row;

  // Frame size clamping to the range two up to the maximum.
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [10:0] hi);
    logic [SizeW-1:0] r;
    if (v < 7'd2) begin
      r = 7'd2;
    end else if ({4'b0, v} > hi) begin
      r = SizeW'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Input decoding.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign query_fire = in_fire && (in_kind_i == KIND_QUERY);
  assign col_ext    = {1'b0, in_column_i};
  assign row_ext    = {1'b0, in_row_i};
  assign in_frame   = (col_ext < width_q) && (row_ext < height_q);
  assign in_store   = ({5'b0, in_column_i} < MaxW) && ({5'b0, in_row_i} < MaxH);
  assign mem_we     = in_fire && (in_kind_i == KIND_STORE) && in_store;
  assign wr_pixel   = '{red: in_red_i, green: in_green_i, blue: in_blue_i};

  // Neighbour order: right, left, lower, upper.
  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        rd_col = right_q;
        rd_row = row_q;
      end
      2'd1: begin
        rd_col = left_q;
        rd_row = row_q;
      end
      2'd2: begin
        rd_col = col_q;
        rd_row = down_q;
      end
      default: begin
        rd_col = col_q;
        rd_row = up_q;
      end
    endcase
  end

  // The single memory port serves stores when idle and neighbour reads otherwise.
  always_comb begin
    if (state_q == S_IDLE) begin
      mem_addr = AddrW'(in_row_i) * AddrW'(MAX_WIDTH) + AddrW'(in_column_i);
    end else begin
      mem_addr = AddrW'(rd_row) * AddrW'(MAX_WIDTH) + AddrW'(rd_col);
    end
  end

  // Frame memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wr_pixel;
    end
    mem_rdata_q <= mem_q[mem_addr];
  end

  // Configuration registers; the port is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        width_q <= clamp_size(cfg_data_i, MaxW);
      end else if (cfg_index_i == CFG_FRAME_HEIGHT) begin
        height_q <= clamp_size(cfg_data_i, MaxH);
      end
    end
  end

  // Neighbour coordinates with wraparound, taken when a query is accepted.
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      col_q   <= col_ext;
      row_q   <= row_ext;
      left_q  <= (in_column_i == '0) ? (width_q - 7'd1) : (col_ext - 7'd1);
      right_q <= ((col_ext + 7'd1) >= width_q) ? 7'd0 : (col_ext + 7'd1);
      up_q    <= (in_row_i == '0) ? (height_q - 7'd1) : (row_ext - 7'd1);
      down_q  <= ((row_ext + 7'd1) >= height_q) ? 7'd0 : (row_ext + 7'd1);
    end
  end

  // Energy accumulation: the first pixel of each pair is held, the second closes it.
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      acc_q <= '0;
    end else if (rd_pend_q) begin
      if (!rd_odd_q) begin
        hold_q <= mem_rdata_q;
      end else begin
        acc_q <= acc_q + EnergyW'(pair_energy(hold_q, mem_rdata_q));
      end
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_odd_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_energy_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          rd_pend_q <= 1'b0;
          cnt_q     <= '0;
          if (query_fire) begin
            state_q <= in_frame ? S_READ : S_PUSH;
          end
        end
        S_READ: begin
          rd_pend_q <= 1'b1;
          rd_odd_q  <= cnt_q[0];
          cnt_q     <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rd_pend_q <= 1'b0;
          state_q   <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_energy_q <= acc_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_pixel_energy_o = out_energy_q;

  // Checks.
  `DGPE_ASSERT(a_no_store_in_query, (state_q != S_IDLE) |-> !mem_we, "store during a query")
  `DGPE_ASSERT(a_read_in_window, rd_pend_q |-> (state_q == S_READ || state_q == S_DRAIN),
               "read data outside the read window")
  `DGPE_ASSERT(a_idle_no_read, !in_stall_o |-> !rd_pend_q, "pending read while accepting")
  `DGPE_ASSERT(a_push_delivers, (state_q == S_PUSH && !out_stall_i) |=> out_valid_o,
               "result not presented")
  `DGPE_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

`default_nettype wire

### dv/dual_gradient_pixel_energy_tb.sv
`default_nettype none

module dual_gradient_pixel_energy_tb;
  import dgpe_pkg::*;

  localparam int unsigned FRAME_MAX  = 64;
  localparam int unsigned STORE_SIZE = FRAME_MAX * FRAME_MAX;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_SPAN  = 400;
  localparam int unsigned HOLD_AFTER = 40;
  localparam int unsigned SETTLE     = 10;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 100;

  // Register indexes beyond the register list; writes to them must do nothing.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  typedef struct {
    logic              kind;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    pixel_t            px;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic               in_kind = KIND_STORE;
  logic [CoordW-1:0]  in_column = '0;
  logic [CoordW-1:0]  in_row = '0;
  logic [ChanW-1:0]   in_red = '0;
  logic [ChanW-1:0]   in_green = '0;
  logic [ChanW-1:0]   in_blue = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [EnergyW-1:0] out_pixel_energy_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [SizeW-1:0]   cfg_data = '0;

  dual_gradient_pixel_energy dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .in_kind_i          (in_kind),
    .in_column_i        (in_column),
    .in_row_i           (in_row),
    .in_red_i           (in_red),
    .in_green_i         (in_green),
    .in_blue_i          (in_blue),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .out_pixel_energy_o (out_pixel_energy_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  // Clock with a 12 unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Frame sizes in use, and the predicted contents of the pixel store.
  int unsigned        frame_w = FRAME_MAX;
  int unsigned        frame_h = FRAME_MAX;
  pixel_t             frame_pixels [STORE_SIZE];
  // Entries that the stimulus has already planned to write.
  bit                 seeded [STORE_SIZE];
  word_t              pending [$];
  logic [EnergyW-1:0] energy_due [$];
  int unsigned        err_count = 0;
  int unsigned        results_seen = 0;
  int unsigned        phase_items;

  function automatic int unsigned size_in_use(input logic [SizeW-1:0] val,
                                              input int unsigned limit);
    if (val < 2) return 2;
    if (val > limit) return limit;
    return 32'(val);
  endfunction

  function automatic int unsigned diff_sq(input logic [ChanW-1:0] a, input logic [ChanW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic int unsigned gradient_sq(input pixel_t a, input pixel_t b);
    return diff_sq(a.red, b.red) + diff_sq(a.green, b.green) + diff_sq(a.blue, b.blue);
  endfunction

  function automatic int unsigned left_of(input int unsigned col);
    return (col == 0) ? frame_w - 1 : col - 1;
  endfunction

  function automatic int unsigned right_of(input int unsigned col);
    return (col + 1 >= frame_w) ? 0 : col + 1;
  endfunction

  function automatic int unsigned above(input int unsigned row);
    return (row == 0) ? frame_h - 1 : row - 1;
  endfunction

  function automatic int unsigned below(input int unsigned row);
    return (row + 1 >= frame_h) ? 0 : row + 1;
  endfunction

  // Dual-gradient energy with wraparound; zero for a position outside the frame.
  function automatic logic [EnergyW-1:0] predict_energy(input int unsigned col,
                                                        input int unsigned row);
    int unsigned e;
    if (col >= frame_w || row >= frame_h) return '0;
    e = gradient_sq(frame_pixels[row * FRAME_MAX + right_of(col)],
                    frame_pixels[row * FRAME_MAX + left_of(col)])
      + gradient_sq(frame_pixels[below(row) * FRAME_MAX + col],
                    frame_pixels[above(row) * FRAME_MAX + col]);
    return e[EnergyW-1:0];
  endfunction

  // Updates the predicted store, or queues the expected energy, for an accepted word.
  task automatic record_word(input word_t w);
    if (w.kind == KIND_STORE) begin
      frame_pixels[w.row * FRAME_MAX + w.column] = w.px;
    end else begin
      energy_due.push_back(predict_energy(w.column, w.row));
    end
  endtask

  function automatic logic [ChanW-1:0] random_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = random_chan();
    p.green = random_chan();
    p.blue  = random_chan();
    return p;
  endfunction

  task automatic push_store(input int unsigned col, input int unsigned row, input pixel_t px);
    word_t w;
    w.kind   = KIND_STORE;
    w.column = CoordW'(col);
    w.row    = CoordW'(row);
    w.px     = px;
    pending.push_back(w);
    seeded[row * FRAME_MAX + col] = 1'b1;
    phase_items++;
  endtask

  task automatic seed_pixel(input int unsigned col, input int unsigned row);
    if (!seeded[row * FRAME_MAX + col]) push_store(col, row, random_pixel());
  endtask

  // A query inside the frame is preceded by writes of any neighbour not yet written.
  task automatic push_query(input int unsigned col, input int unsigned row);
    word_t w;
    if (col < frame_w && row < frame_h) begin
      seed_pixel(left_of(col), row);
      seed_pixel(right_of(col), row);
      seed_pixel(col, above(row));
      seed_pixel(col, below(row));
    end
    w.kind   = KIND_QUERY;
    w.column = CoordW'(col);
    w.row    = CoordW'(row);
    w.px     = random_pixel();
    pending.push_back(w);
    phase_items++;
  endtask

  // Waits until every word has gone in and every result has come out.
  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || in_valid || energy_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SizeW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  frame_w = size_in_use(val, FRAME_MAX);
      CFG_FRAME_HEIGHT: frame_h = size_in_use(val, FRAME_MAX);
      default: ;
    endcase
  endtask

  function automatic logic [SizeW-1:0] random_size();
    case ($urandom_range(0, 5))
      0: return SizeW'($urandom_range(0, 127));
      1: return SizeW'(FRAME_MAX);
      2: return SizeW'(2);
      default: return SizeW'($urandom_range(2, 8));
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  word_t       cur_word;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) record_word(cur_word);
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_word = pending.pop_front();
          in_valid  <= 1'b1;
          in_kind   <= cur_word.kind;
          in_column <= cur_word.column;
          in_row    <= cur_word.row;
          in_red    <= cur_word.px.red;
          in_green  <= cur_word.px.green;
          in_blue   <= cur_word.px.blue;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls in changing modes, with one long hold-off.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    logic [EnergyW-1:0] want;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (energy_due.size() == 0) begin
          $error("result word with no query waiting: pixel_energy %0d", out_pixel_energy_o);
          err_count++;
        end else begin
          want = energy_due.pop_front();
          if (out_pixel_energy_o !== want) begin
            $error("pixel_energy: expected %0d, actual %0d", want, out_pixel_energy_o);
            err_count++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= HOLD_AFTER && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_SPAN;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int unsigned pick;
    int unsigned col;
    int unsigned row;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full 64 by 64 frame: the largest energy, with both neighbours wrapping.
    phase_items = 0;
    push_store(1, 0, '1);
    push_store(FRAME_MAX - 1, 0, '0);
    push_store(0, 1, '1);
    push_store(0, FRAME_MAX - 1, '0);
    push_query(0, 0);
    drain();

    // Sizes below the minimum act as 2; unused indexes are left alone.
    write_reg(CFG_FRAME_WIDTH, 7'd0);
    write_reg(CFG_FRAME_HEIGHT, 7'd1);
    write_reg(CFG_SPARE_A, 7'h55);
    write_reg(CFG_SPARE_B, 7'h2a);
    push_query(0, 0);
    push_query(1, 1);
    push_query(5, 1);
    push_query(1, 40);
    drain();

    // Sizes above the maximum act as 64; the far corner wraps both ways.
    write_reg(CFG_FRAME_WIDTH, 7'd127);
    write_reg(CFG_FRAME_HEIGHT, 7'd65);
    push_query(FRAME_MAX - 1, FRAME_MAX - 1);
    push_query(FRAME_MAX - 1, 0);
    drain();

    // Random phases, each under its own frame size.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_FRAME_WIDTH, random_size());
      write_reg(CFG_FRAME_HEIGHT, random_size());
      phase_items = 0;
      while (phase_items < PHASE_LEN) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          if ($urandom_range(0, 9) < 7) begin
            col = $urandom_range(0, frame_w - 1);
            row = $urandom_range(0, frame_h - 1);
          end else begin
            col = $urandom_range(0, FRAME_MAX - 1);
            row = $urandom_range(0, FRAME_MAX - 1);
          end
          push_store(col, row, random_pixel());
        end else if (pick < 85) begin
          push_query($urandom_range(0, frame_w - 1), $urandom_range(0, frame_h - 1));
        end else begin
          push_query($urandom_range(0, FRAME_MAX - 1), $urandom_range(0, FRAME_MAX - 1));
        end
      end
      drain();
    end

    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/dgpe_pkg.sv
src/dual_gradient_pixel_energy.sv
dv/dual_gradient_pixel_energy_tb.sv
